// File: sv/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg - shared constants and types for the 2D box overlap test
// Fixed-point constants of the sine pipeline, quadrant and axis codes, result bundle.
// ----------------------------------------------------------------------------
package obb_pkg;

  localparam int TAG_BITS = 8;

  // Q30 fixed point used inside the sine evaluation
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Horner levels of the sine series, innermost divisor first
  localparam int NUM_LVL = 5;
  localparam logic [6:0] SIN_DIV [NUM_LVL] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};

  // latencies in cycles
  localparam int QSIN_LAT = 2 + 3 * NUM_LVL + 2;
  localparam int TRIG_LAT = QSIN_LAT + 1;
  localparam int SAT_LAT  = 6;

  // quadrant codes of a binary angle
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // axis codes
  localparam int NUM_AXES = 4;
  localparam logic [2:0] AXIS_FIRST_W  = 3'd0;
  localparam logic [2:0] AXIS_FIRST_H  = 3'd1;
  localparam logic [2:0] AXIS_SECOND_W = 3'd2;
  localparam logic [2:0] AXIS_SECOND_H = 3'd3;
  localparam logic [2:0] NO_AXIS       = 3'd4;

  typedef struct packed {
    logic       collide;
    logic       boxes_overlap;
    logic [2:0] separating_axis;
  } obb_result_t;

endpackage

// File: sv/obb_qsin.sv
// ----------------------------------------------------------------------------
// obb_qsin - pipelined quarter-turn sine
// sin(pi/2*u), u in Q30, Horner series with truncating constant divides.
// ----------------------------------------------------------------------------
module obb_qsin #(
  parameter int FRAC_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [30:0]          in_u,
  output logic                 out_vld,
  output logic [FRAC_BITS:0]   out_val
);

  localparam int NL = obb_pkg::NUM_LVL;

  // stage a: t = u * pi/2
  logic        a_vld_r;
  logic [30:0] a_t_r;
  logic [61:0] a_prod;
  assign a_prod = 62'(in_u) * 62'(obb_pkg::HALF_PI_Q30);

  // stage b: t2 = t * t
  logic        b_vld_r;
  logic [30:0] b_t_r;
  logic [31:0] b_t2_r;
  logic [61:0] b_prod;
  assign b_prod = 62'(a_t_r) * 62'(a_t_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_t_r  <= a_prod[60:30];
    b_t_r  <= a_t_r;
    b_t2_r <= b_prod[61:30];
  end

  logic        lv_vld [NL+1];
  logic [30:0] lv_t   [NL+1];
  logic [31:0] lv_t2  [NL+1];
  logic [30:0] lv_p   [NL+1];

  // the first level multiplies by one, so t2 passes through unchanged
  assign lv_vld[0] = b_vld_r;
  assign lv_t[0]   = b_t_r;
  assign lv_t2[0]  = b_t2_r;
  assign lv_p[0]   = obb_pkg::ONE_Q30;

  for (genvar g = 0; g < NL; g++) begin : g_lvl
    localparam logic [6:0]  DIV   = obb_pkg::SIN_DIV[g];
    localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(DIV));

    logic        s1_vld_r, s2_vld_r, s3_vld_r;
    logic [30:0] s1_t_r, s2_t_r, s3_t_r;
    logic [31:0] s1_t2_r, s2_t2_r, s3_t2_r;
    logic [31:0] s1_m_r, s2_m_r;
    logic [63:0] s2_dp_r;
    logic [30:0] s3_p_r;

    logic [61:0] mprod;
    logic [63:0] dprod;
    logic [31:0] q, q_fix;
    logic [38:0] rem;

    assign mprod = 62'(lv_t2[g]) * 62'(lv_p[g]);
    assign dprod = 64'(s1_m_r) * 64'(RECIP);
    // reciprocal estimate is exact or one short
    assign q     = s2_dp_r[63:32];
    assign rem   = 39'(s2_m_r) - 39'(q) * 39'(DIV);
    assign q_fix = (rem >= 39'(DIV)) ? q + 32'd1 : q;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s1_vld_r <= 1'b0;
        s2_vld_r <= 1'b0;
        s3_vld_r <= 1'b0;
      end else begin
        s1_vld_r <= lv_vld[g];
        s2_vld_r <= s1_vld_r;
        s3_vld_r <= s2_vld_r;
      end
    end

    always_ff @(posedge clk) begin
      s1_t_r  <= lv_t[g];
      s1_t2_r <= lv_t2[g];
      s1_m_r  <= mprod[61:30];
      s2_t_r  <= s1_t_r;
      s2_t2_r <= s1_t2_r;
      s2_m_r  <= s1_m_r;
      s2_dp_r <= dprod;
      s3_t_r  <= s2_t_r;
      s3_t2_r <= s2_t2_r;
      s3_p_r  <= obb_pkg::ONE_Q30 - q_fix[30:0];
    end

    assign lv_vld[g+1] = s3_vld_r;
    assign lv_t[g+1]   = s3_t_r;
    assign lv_t2[g+1]  = s3_t2_r;
    assign lv_p[g+1]   = s3_p_r;
  end

  // final: t * p, then round to FRAC_BITS
  logic        f1_vld_r, f2_vld_r;
  logic [31:0] f1_p_r;
  logic [FRAC_BITS:0] f2_val_r;
  logic [61:0] fprod;
  logic [31:0] rsum;

  assign fprod = 62'(lv_t[NL]) * 62'(lv_p[NL]);
  assign rsum  = f1_p_r + (32'd1 << (29 - FRAC_BITS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= lv_vld[NL];
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_p_r   <= fprod[61:30];
    f2_val_r <= rsum[30:30-FRAC_BITS];
  end

  assign out_vld = f2_vld_r;
  assign out_val = f2_val_r;

endmodule

// File: sv/obb_trig.sv
// ----------------------------------------------------------------------------
// obb_trig - cosine and sine of a binary angle
// Two quarter-sine pipelines plus quadrant fold-out.
// ----------------------------------------------------------------------------
module obb_trig #(
  parameter int ANGLE_BITS = 12,
  parameter int FRAC_BITS  = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [ANGLE_BITS-1:0]        in_angle,
  output logic                         out_vld,
  output logic signed [FRAC_BITS+1:0]  out_cos,
  output logic signed [FRAC_BITS+1:0]  out_sin
);

  localparam int SH  = 32 - ANGLE_BITS;
  localparam int LAT = obb_pkg::QSIN_LAT;

  logic [30:0] u_sin, u_cos;
  assign u_sin = 31'(in_angle[ANGLE_BITS-3:0]) << SH;
  assign u_cos = obb_pkg::ONE_Q30 - u_sin;

  logic               sn_vld, cs_vld;
  logic [FRAC_BITS:0] sn_val, cs_val;

  obb_qsin #(.FRAC_BITS(FRAC_BITS)) u_qsin_sin (
    .clk(clk), .rst_n(rst_n), .in_vld(in_vld), .in_u(u_sin),
    .out_vld(sn_vld), .out_val(sn_val)
  );

  obb_qsin #(.FRAC_BITS(FRAC_BITS)) u_qsin_cos (
    .clk(clk), .rst_n(rst_n), .in_vld(in_vld), .in_u(u_cos),
    .out_vld(cs_vld), .out_val(cs_val)
  );

  logic [1:0] quad_r [LAT];

  always_ff @(posedge clk) begin
    quad_r[0] <= in_angle[ANGLE_BITS-1:ANGLE_BITS-2];
    for (int i = 1; i < LAT; i++) begin
      quad_r[i] <= quad_r[i-1];
    end
  end

  logic signed [FRAC_BITS+1:0] sn, cs;
  logic signed [FRAC_BITS+1:0] cos_nxt, sin_nxt;
  assign sn = signed'({1'b0, sn_val});
  assign cs = signed'({1'b0, cs_val});

  always_comb begin
    case (quad_r[LAT-1])
      obb_pkg::QUAD_0: begin cos_nxt = cs;  sin_nxt = sn;  end
      obb_pkg::QUAD_1: begin cos_nxt = -sn; sin_nxt = cs;  end
      obb_pkg::QUAD_2: begin cos_nxt = -cs; sin_nxt = -sn; end
      default:         begin cos_nxt = sn;  sin_nxt = -cs; end
    endcase
  end

  logic                        vld_r;
  logic signed [FRAC_BITS+1:0] cos_r, sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= sn_vld & cs_vld;
    end
  end

  always_ff @(posedge clk) begin
    cos_r <= cos_nxt;
    sin_r <= sin_nxt;
  end

  assign out_vld = vld_r;
  assign out_cos = cos_r;
  assign out_sin = sin_r;

endmodule

// File: sv/obb_sat.sv
// ----------------------------------------------------------------------------
// obb_sat - separating axis test over the edge axes of both boxes
// Six stages: axes, products, sums, size scaling, compare, priority pick.
// ----------------------------------------------------------------------------
module obb_sat #(
  parameter int COORD_BITS = 16,
  parameter int SIZE_BITS  = 12,
  parameter int FRAC_BITS  = 14
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic signed [COORD_BITS-1:0]   in_x0,
  input  logic signed [COORD_BITS-1:0]   in_y0,
  input  logic [SIZE_BITS-1:0]           in_w0,
  input  logic [SIZE_BITS-1:0]           in_h0,
  input  logic signed [FRAC_BITS+1:0]    in_c0,
  input  logic signed [FRAC_BITS+1:0]    in_s0,
  input  logic [obb_pkg::TAG_BITS-1:0]   in_tag0,
  input  logic signed [COORD_BITS-1:0]   in_x1,
  input  logic signed [COORD_BITS-1:0]   in_y1,
  input  logic [SIZE_BITS-1:0]           in_w1,
  input  logic [SIZE_BITS-1:0]           in_h1,
  input  logic signed [FRAC_BITS+1:0]    in_c1,
  input  logic signed [FRAC_BITS+1:0]    in_s1,
  input  logic [obb_pkg::TAG_BITS-1:0]   in_tag1,
  output logic                           out_vld,
  output obb_pkg::obb_result_t           out_res
);

  localparam int NA  = obb_pkg::NUM_AXES;
  localparam int TW  = FRAC_BITS + 2;          // trig word
  localparam int DXW = COORD_BITS + 2;         // doubled center offset
  localparam int PDW = TW + DXW;               // offset product
  localparam int DSW = PDW + 1;                // distance
  localparam int PW  = 2 * TW;                 // trig product
  localparam int DTW = PW + 1;                 // dot product
  localparam int EPW = DTW + SIZE_BITS;        // scaled projection
  localparam int EW  = EPW + 2;                // extent sum
  localparam int CW  = (DSW > EW) ? DSW : EW;

  logic [obb_pkg::SAT_LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[obb_pkg::SAT_LAT-2:0], in_vld};
    end
  end

  // ---- stage 1: offset and axes
  logic signed [COORD_BITS:0] ddx, ddy;
  assign ddx = (COORD_BITS+1)'(in_x0) - (COORD_BITS+1)'(in_x1);
  assign ddy = (COORD_BITS+1)'(in_y0) - (COORD_BITS+1)'(in_y1);

  logic signed [DXW-1:0] s1_dx_r, s1_dy_r;
  logic signed [TW-1:0]  s1_ax_r [NA];
  logic signed [TW-1:0]  s1_ay_r [NA];
  logic signed [TW-1:0]  s1_c_r [2];
  logic signed [TW-1:0]  s1_s_r [2];
  logic [NA-1:0]         s1_en_r;
  logic [SIZE_BITS-1:0]  s1_w_r [2];
  logic [SIZE_BITS-1:0]  s1_h_r [2];
  logic [obb_pkg::TAG_BITS-1:0] s1_tag_r [2];

  always_ff @(posedge clk) begin
    s1_dx_r <= DXW'(ddx) <<< 1;
    s1_dy_r <= DXW'(ddy) <<< 1;
    s1_ax_r[2'(obb_pkg::AXIS_FIRST_W)]  <= in_c0;
    s1_ay_r[2'(obb_pkg::AXIS_FIRST_W)]  <= in_s0;
    s1_ax_r[2'(obb_pkg::AXIS_FIRST_H)]  <= in_s0;
    s1_ay_r[2'(obb_pkg::AXIS_FIRST_H)]  <= -in_c0;
    s1_ax_r[2'(obb_pkg::AXIS_SECOND_W)] <= in_c1;
    s1_ay_r[2'(obb_pkg::AXIS_SECOND_W)] <= in_s1;
    s1_ax_r[2'(obb_pkg::AXIS_SECOND_H)] <= in_s1;
    s1_ay_r[2'(obb_pkg::AXIS_SECOND_H)] <= -in_c1;
    // zero side: axis never separates
    s1_en_r <= {in_h1 != '0, in_w1 != '0, in_h0 != '0, in_w0 != '0};
    s1_c_r[0] <= in_c0;  s1_c_r[1] <= in_c1;
    s1_s_r[0] <= in_s0;  s1_s_r[1] <= in_s1;
    s1_w_r[0] <= in_w0;  s1_w_r[1] <= in_w1;
    s1_h_r[0] <= in_h0;  s1_h_r[1] <= in_h1;
    s1_tag_r[0] <= in_tag0;  s1_tag_r[1] <= in_tag1;
  end

  // ---- stage 2: products
  logic signed [PDW-1:0] s2_pdx_r [NA];
  logic signed [PDW-1:0] s2_pdy_r [NA];
  logic signed [PW-1:0]  s2_pcc_r [NA][2];
  logic signed [PW-1:0]  s2_pss_r [NA][2];
  logic signed [PW-1:0]  s2_pcs_r [NA][2];
  logic signed [PW-1:0]  s2_psc_r [NA][2];
  logic [NA-1:0]         s2_en_r;
  logic [SIZE_BITS-1:0]  s2_w_r [2];
  logic [SIZE_BITS-1:0]  s2_h_r [2];
  logic [obb_pkg::TAG_BITS-1:0] s2_tag_r [2];

  always_ff @(posedge clk) begin
    for (int a = 0; a < NA; a++) begin
      s2_pdx_r[a] <= PDW'(s1_ax_r[a]) * PDW'(s1_dx_r);
      s2_pdy_r[a] <= PDW'(s1_ay_r[a]) * PDW'(s1_dy_r);
      for (int b = 0; b < 2; b++) begin
        s2_pcc_r[a][b] <= PW'(s1_ax_r[a]) * PW'(s1_c_r[b]);
        s2_pss_r[a][b] <= PW'(s1_ay_r[a]) * PW'(s1_s_r[b]);
        s2_pcs_r[a][b] <= PW'(s1_ax_r[a]) * PW'(s1_s_r[b]);
        s2_psc_r[a][b] <= PW'(s1_ay_r[a]) * PW'(s1_c_r[b]);
      end
    end
    s2_en_r  <= s1_en_r;
    s2_w_r   <= s1_w_r;
    s2_h_r   <= s1_h_r;
    s2_tag_r <= s1_tag_r;
  end

  // ---- stage 3: sums and magnitudes
  logic signed [DSW-1:0] dsum [NA];
  logic signed [DTW-1:0] t1sum [NA][2];
  logic signed [DTW-1:0] t2sum [NA][2];

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      dsum[a] = DSW'(s2_pdx_r[a]) + DSW'(s2_pdy_r[a]);
      for (int b = 0; b < 2; b++) begin
        t1sum[a][b] = DTW'(s2_pcc_r[a][b]) + DTW'(s2_pss_r[a][b]);
        t2sum[a][b] = DTW'(s2_pcs_r[a][b]) - DTW'(s2_psc_r[a][b]);
      end
    end
  end

  logic [DSW-1:0]        s3_dist_r [NA];
  logic [DTW-1:0]        s3_d1_r [NA][2];
  logic [DTW-1:0]        s3_d2_r [NA][2];
  logic [NA-1:0]         s3_en_r;
  logic [SIZE_BITS-1:0]  s3_w_r [2];
  logic [SIZE_BITS-1:0]  s3_h_r [2];
  logic [obb_pkg::TAG_BITS-1:0] s3_tag_r [2];

  always_ff @(posedge clk) begin
    for (int a = 0; a < NA; a++) begin
      s3_dist_r[a] <= dsum[a][DSW-1] ? -dsum[a] : dsum[a];
      for (int b = 0; b < 2; b++) begin
        s3_d1_r[a][b] <= t1sum[a][b][DTW-1] ? -t1sum[a][b] : t1sum[a][b];
        s3_d2_r[a][b] <= t2sum[a][b][DTW-1] ? -t2sum[a][b] : t2sum[a][b];
      end
    end
    s3_en_r  <= s2_en_r;
    s3_w_r   <= s2_w_r;
    s3_h_r   <= s2_h_r;
    s3_tag_r <= s2_tag_r;
  end

  // ---- stage 4: scale projections by side lengths
  logic [DSW-1:0]        s4_dist_r [NA];
  logic [EPW-1:0]        s4_ew_r [NA][2];
  logic [EPW-1:0]        s4_eh_r [NA][2];
  logic [NA-1:0]         s4_en_r;
  logic [obb_pkg::TAG_BITS-1:0] s4_tag_r [2];

  always_ff @(posedge clk) begin
    for (int a = 0; a < NA; a++) begin
      for (int b = 0; b < 2; b++) begin
        s4_ew_r[a][b] <= EPW'(s3_d1_r[a][b]) * EPW'(s3_w_r[b]);
        s4_eh_r[a][b] <= EPW'(s3_d2_r[a][b]) * EPW'(s3_h_r[b]);
      end
    end
    s4_dist_r <= s3_dist_r;
    s4_en_r   <= s3_en_r;
    s4_tag_r  <= s3_tag_r;
  end

  // ---- stage 5: extent sum and compare
  logic [EW-1:0] ext [NA];
  logic [NA-1:0] sep_nxt;

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      ext[a] = EW'(s4_ew_r[a][0]) + EW'(s4_eh_r[a][0])
             + EW'(s4_ew_r[a][1]) + EW'(s4_eh_r[a][1]);
      sep_nxt[a] = s4_en_r[a] && (CW'(s4_dist_r[a]) > CW'(ext[a] >> FRAC_BITS));
    end
  end

  logic [NA-1:0] s5_sep_r;
  logic [obb_pkg::TAG_BITS-1:0] s5_tag_r [2];

  always_ff @(posedge clk) begin
    s5_sep_r <= sep_nxt;
    s5_tag_r <= s4_tag_r;
  end

  // ---- stage 6: first separating axis
  obb_pkg::obb_result_t res_nxt, res_r;

  always_comb begin
    res_nxt.separating_axis = obb_pkg::NO_AXIS;
    if (s5_sep_r[0]) begin
      res_nxt.separating_axis = obb_pkg::AXIS_FIRST_W;
    end else if (s5_sep_r[1]) begin
      res_nxt.separating_axis = obb_pkg::AXIS_FIRST_H;
    end else if (s5_sep_r[2]) begin
      res_nxt.separating_axis = obb_pkg::AXIS_SECOND_W;
    end else if (s5_sep_r[3]) begin
      res_nxt.separating_axis = obb_pkg::AXIS_SECOND_H;
    end
    res_nxt.boxes_overlap = (s5_sep_r == '0);
    res_nxt.collide       = res_nxt.boxes_overlap && (s5_tag_r[0] != s5_tag_r[1]);
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_vld = vld_r[obb_pkg::SAT_LAT-1];
  assign out_res = res_r;

endmodule

// File: sv/obb_overlap_test_2d_top.sv
// ----------------------------------------------------------------------------
// obb_overlap_test_2d_top - oriented rectangle overlap test, one pair per beat
// Separating axis test of two rotated boxes on the edge axes of both boxes.
// ----------------------------------------------------------------------------
// A pair is taken on any cycle with start high; busy is always low, so a new
// pair may enter every clock. Each pair yields exactly one result beat on the
// out_ ports, flagged by out_valid for a single cycle. Each pair passes
// through the sine/cosine pipeline, in which the five-level series with its
// constant divides dominates, then through axis projection, compare and
// first-axis pick, whose last stage is the output register. There is no
// backpressure: the receiver must take every result beat when it appears.
// Results come out in the order the pairs went in. A box side of zero drops
// that side's axis from the test; if all four sides are zero the boxes are
// reported as overlapping. Touching boxes count as overlapping. collide is
// boxes_overlap gated by differing tags; separating_axis names the first
// separating axis (first box width, first height, second width, second
// height) or 4 when none separates.
// ----------------------------------------------------------------------------
module obb_overlap_test_2d_top #(
  parameter int COORD_BITS     = 16,
  parameter int SIZE_BITS      = 12,
  parameter int ANGLE_BITS     = 12,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_BITS-1:0]         in_first_center_x,
  input  logic [COORD_BITS-1:0]         in_first_center_y,
  input  logic [SIZE_BITS-1:0]          in_first_width,
  input  logic [SIZE_BITS-1:0]          in_first_height,
  input  logic [ANGLE_BITS-1:0]         in_first_angle,
  input  logic [obb_pkg::TAG_BITS-1:0]  in_first_tag,
  input  logic [COORD_BITS-1:0]         in_second_center_x,
  input  logic [COORD_BITS-1:0]         in_second_center_y,
  input  logic [SIZE_BITS-1:0]          in_second_width,
  input  logic [SIZE_BITS-1:0]          in_second_height,
  input  logic [ANGLE_BITS-1:0]         in_second_angle,
  input  logic [obb_pkg::TAG_BITS-1:0]  in_second_tag,
  output logic                          out_valid,
  output logic                          out_collide,
  output logic                          out_boxes_overlap,
  output logic [2:0]                    out_separating_axis
);

  localparam int TW   = TRIG_FRAC_BITS + 2;
  localparam int BOXW = 2 * COORD_BITS + 2 * SIZE_BITS + obb_pkg::TAG_BITS;
  localparam int DLAT = obb_pkg::TRIG_LAT;

  // no backpressure, the pipeline never stalls
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // ---- rotation of each box
  logic                 t0_vld, t1_vld;
  logic signed [TW-1:0] c0, s0, c1, s1;

  obb_trig #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(TRIG_FRAC_BITS)) u_trig_first (
    .clk(clk), .rst_n(rst_n), .in_vld(accept), .in_angle(in_first_angle),
    .out_vld(t0_vld), .out_cos(c0), .out_sin(s0)
  );

  obb_trig #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(TRIG_FRAC_BITS)) u_trig_second (
    .clk(clk), .rst_n(rst_n), .in_vld(accept), .in_angle(in_second_angle),
    .out_vld(t1_vld), .out_cos(c1), .out_sin(s1)
  );

  // ---- box geometry waits alongside the trig pipeline
  logic [2*BOXW-1:0] geo_r [DLAT];

  always_ff @(posedge clk) begin
    geo_r[0] <= {in_first_center_x, in_first_center_y, in_first_width,
                 in_first_height, in_first_tag,
                 in_second_center_x, in_second_center_y, in_second_width,
                 in_second_height, in_second_tag};
    for (int i = 1; i < DLAT; i++) begin
      geo_r[i] <= geo_r[i-1];
    end
  end

  logic signed [COORD_BITS-1:0]  x0, y0, x1, y1;
  logic [SIZE_BITS-1:0]          w0, h0, w1, h1;
  logic [obb_pkg::TAG_BITS-1:0]  tag0, tag1;

  assign {x0, y0, w0, h0, tag0, x1, y1, w1, h1, tag1} = geo_r[DLAT-1];

  // ---- axis test
  logic                 sat_vld;
  obb_pkg::obb_result_t sat_res;

  obb_sat #(
    .COORD_BITS(COORD_BITS), .SIZE_BITS(SIZE_BITS), .FRAC_BITS(TRIG_FRAC_BITS)
  ) u_sat (
    .clk(clk), .rst_n(rst_n), .in_vld(t0_vld & t1_vld),
    .in_x0(x0), .in_y0(y0), .in_w0(w0), .in_h0(h0),
    .in_c0(c0), .in_s0(s0), .in_tag0(tag0),
    .in_x1(x1), .in_y1(y1), .in_w1(w1), .in_h1(h1),
    .in_c1(c1), .in_s1(s1), .in_tag1(tag1),
    .out_vld(sat_vld), .out_res(sat_res)
  );

  assign out_valid           = sat_vld;
  assign out_collide         = sat_res.collide;
  assign out_boxes_overlap   = sat_res.boxes_overlap;
  assign out_separating_axis = sat_res.separating_axis;

endmodule
